FILE: src/irpwb_pkg.sv
// ----------------------------------------------------------------------------
// irpwb_pkg
// Shared types and constants for the IR pulse-width beacon framer: register
// indexes, reset values, frame part state codes and the result bundle.
// ----------------------------------------------------------------------------
package irpwb_pkg;

	// fixed field widths
	localparam int EMITTER_COUNT = 4;
	localparam int TICK_REG_W    = 20;
	localparam int PCOUNT_W      = 4;
	localparam int BOARD_W       = 2;
	localparam int REG_INDEX_W   = 3;
	localparam int PART_CODE_W   = 2;

	// default counter width for the tick counter
	localparam int COUNT_WIDTH_DEFAULT = 20;

	// register indexes
	localparam logic [REG_INDEX_W-1:0] REG_PREAMBLE_COUNT = 3'd0;
	localparam logic [REG_INDEX_W-1:0] REG_BOARD_ID       = 3'd1;
	localparam logic [REG_INDEX_W-1:0] REG_PREAMBLE_TICKS = 3'd2;
	localparam logic [REG_INDEX_W-1:0] REG_SHORT_TICKS    = 3'd3;
	localparam logic [REG_INDEX_W-1:0] REG_LONG_TICKS     = 3'd4;
	localparam logic [REG_INDEX_W-1:0] REG_RUN_ENABLE     = 3'd5;

	// register reset values
	localparam logic [PCOUNT_W-1:0]   RST_PREAMBLE_COUNT = 4'd5;
	localparam logic [BOARD_W-1:0]    RST_BOARD_ID       = 2'd0;
	localparam logic [TICK_REG_W-1:0] RST_PREAMBLE_TICKS = 20'd150000;
	localparam logic [TICK_REG_W-1:0] RST_SHORT_TICKS    = 20'd70000;
	localparam logic [TICK_REG_W-1:0] RST_LONG_TICKS     = 20'd280000;

	// frame part codes seen on the output
	localparam logic [PART_CODE_W-1:0] CODE_PREAMBLE = 2'd0;
	localparam logic [PART_CODE_W-1:0] CODE_BOARD    = 2'd1;
	localparam logic [PART_CODE_W-1:0] CODE_INDEX    = 2'd2;

	// frame part state, one-hot
	typedef enum logic [2:0] {
		PART_PREAMBLE = 3'b001,
		PART_BOARD    = 3'b010,
		PART_INDEX    = 3'b100
	} part_t;

	// configuration register bundle
	typedef struct packed {
		logic [PCOUNT_W-1:0]   preamble_count;
		logic [BOARD_W-1:0]    board_id;
		logic [TICK_REG_W-1:0] preamble_ticks;
		logic [TICK_REG_W-1:0] short_ticks;
		logic [TICK_REG_W-1:0] long_ticks;
		logic                  run_enable;
	} cfg_t;

	// one result
	typedef struct packed {
		logic [EMITTER_COUNT-1:0] emitter_on;
		logic                     frame_start;
		logic [PART_CODE_W-1:0]   frame_part;
	} res_t;

	// output code of a part state
	function automatic logic [PART_CODE_W-1:0] part_code(input part_t p);
		logic [PART_CODE_W-1:0] c;
		case (p)
			PART_PREAMBLE: c = CODE_PREAMBLE;
			PART_BOARD:    c = CODE_BOARD;
			PART_INDEX:    c = CODE_INDEX;
			default:       c = 2'd3;
		endcase
		return c;
	endfunction

endpackage

FILE: src/irpwb_cfg.sv
// ----------------------------------------------------------------------------
// irpwb_cfg
// Configuration register file: six registers written by index, no read-back.
// ----------------------------------------------------------------------------
module irpwb_cfg import irpwb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [REG_INDEX_W-1:0] cfg_index,
	input  logic [TICK_REG_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.preamble_count <= RST_PREAMBLE_COUNT;
			cfg_q.board_id       <= RST_BOARD_ID;
			cfg_q.preamble_ticks <= RST_PREAMBLE_TICKS;
			cfg_q.short_ticks    <= RST_SHORT_TICKS;
			cfg_q.long_ticks     <= RST_LONG_TICKS;
			cfg_q.run_enable     <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PREAMBLE_COUNT: cfg_q.preamble_count <= cfg_data[PCOUNT_W-1:0];
				REG_BOARD_ID:       cfg_q.board_id       <= cfg_data[BOARD_W-1:0];
				REG_PREAMBLE_TICKS: cfg_q.preamble_ticks <= cfg_data;
				REG_SHORT_TICKS:    cfg_q.short_ticks    <= cfg_data;
				REG_LONG_TICKS:     cfg_q.long_ticks     <= cfg_data;
				REG_RUN_ENABLE:     cfg_q.run_enable     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/irpwb_seq.sv
// ----------------------------------------------------------------------------
// irpwb_seq
// Frame sequencer: position state of the frame, the emitter envelope for the
// current tick and the step to the next tick, one tick per enabled cycle.
// ----------------------------------------------------------------------------
module irpwb_seq import irpwb_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic advance,
	input  cfg_t cfg,
	output res_t res
);

	// length arithmetic wide enough for 2^COUNT_WIDTH and any register value
	localparam int LW = (COUNT_WIDTH + 1 > TICK_REG_W + 1) ? COUNT_WIDTH + 1 : TICK_REG_W + 1;
	localparam logic [LW-1:0] LEN_ONE = {{(LW-1){1'b0}}, 1'b1};
	localparam logic [LW-1:0] LEN_CAP = LEN_ONE << COUNT_WIDTH;

	// a zero length acts as one, anything above 2^COUNT_WIDTH is capped
	function automatic logic [LW-1:0] eff_len(input logic [TICK_REG_W-1:0] r);
		logic [LW-1:0] v;
		v = {{(LW-TICK_REG_W){1'b0}}, r};
		if (v == '0) v = LEN_ONE;
		if (v > LEN_CAP) v = LEN_CAP;
		return v;
	endfunction

	part_t                    part_q;
	logic [PCOUNT_W-1:0]      pulse_index_q;
	logic                     bit_index_q;
	logic                     half_q;
	logic [COUNT_WIDTH-1:0]   tick_count_q;
	logic [EMITTER_COUNT-1:0] emitters_q;

	part_t                    part_d;
	logic [PCOUNT_W-1:0]      pulse_index_d;
	logic                     bit_index_d;
	logic                     half_d;
	logic [COUNT_WIDTH-1:0]   tick_count_d;
	logic [EMITTER_COUNT-1:0] emitters_d;

	part_t                    p;
	logic [PCOUNT_W-1:0]      pi;
	logic                     bi;
	logic                     hf;
	logic [COUNT_WIDTH-1:0]   tc;
	logic                     at_start;
	logic [LW-1:0]            len_pre;
	logic [LW-1:0]            len_short;
	logic [LW-1:0]            len_long;
	logic [LW-1:0]            len;
	logic [LW-1:0]            tc_ext;
	logic [LW-1:0]            tc_inc;
	logic                     tail_on;
	logic                     board_bit;
	logic [EMITTER_COUNT-1:0] val;
	logic [PCOUNT_W:0]        pulse_next;

	assign len_pre   = eff_len(cfg.preamble_ticks);
	assign len_short = eff_len(cfg.short_ticks);
	assign len_long  = eff_len(cfg.long_ticks);

	// envelope and next position for one tick
	always_comb begin
		part_d        = part_q;
		pulse_index_d = pulse_index_q;
		bit_index_d   = bit_index_q;
		half_d        = half_q;
		tick_count_d  = tick_count_q;
		emitters_d    = emitters_q;
		res.emitter_on  = emitters_q;
		res.frame_start = 1'b0;
		res.frame_part  = part_code(part_q);

		p  = part_q;
		pi = pulse_index_q;
		bi = bit_index_q;
		hf = half_q;
		tc = tick_count_q;

		// an unknown part code restarts the frame
		if (p != PART_PREAMBLE && p != PART_BOARD && p != PART_INDEX) begin
			p  = PART_PREAMBLE;
			pi = '0;
			bi = 1'b0;
			hf = 1'b0;
			tc = '0;
		end

		at_start = (p == PART_PREAMBLE) && (pi == '0) && !bi && !hf && (tc == '0);

		// skip an empty or shortened preamble
		if (p == PART_PREAMBLE && pi >= cfg.preamble_count) begin
			p  = PART_BOARD;
			pi = '0;
			bi = 1'b0;
			hf = 1'b0;
			tc = '0;
		end

		tc_ext = {{(LW-COUNT_WIDTH){1'b0}}, tc};
		tc_inc = tc_ext + LEN_ONE;

		// second half of a one bit stays on for long minus short ticks
		tail_on = (len_long > len_short) && (tc_ext < (len_long - len_short));

		board_bit = bi ? cfg.board_id[0] : cfg.board_id[1];

		val = '0;
		case (p)
			PART_PREAMBLE: val = hf ? '0 : '1;
			PART_BOARD:    val = (!hf || (board_bit && tail_on)) ? '1 : '0;
			PART_INDEX: begin
				for (int k = 0; k < EMITTER_COUNT; k++) begin
					val[k] = !hf || ((bi ? k[0] : k[1]) && tail_on);
				end
			end
			default: val = '0;
		endcase

		if (p == PART_PREAMBLE) len = len_pre;
		else len = hf ? len_long : len_short;

		pulse_next = {1'b0, pi} + {{PCOUNT_W{1'b0}}, 1'b1};

		if (advance) begin
			if (at_start && !cfg.run_enable) begin
				// idle at frame start: emitters off, position held
				emitters_d      = '0;
				res.emitter_on  = '0;
				res.frame_start = 1'b0;
				res.frame_part  = CODE_PREAMBLE;
			end else begin
				emitters_d      = val;
				res.emitter_on  = val;
				res.frame_start = at_start;
				res.frame_part  = part_code(p);
				part_d          = p;
				pulse_index_d   = pi;
				bit_index_d     = bi;
				half_d          = hf;
				// end of the current half
				if (tc_inc >= len) begin
					tick_count_d = '0;
					if (!hf) begin
						half_d = 1'b1;
					end else begin
						half_d = 1'b0;
						if (p == PART_PREAMBLE) begin
							if (pulse_next >= {1'b0, cfg.preamble_count}) begin
								part_d        = PART_BOARD;
								pulse_index_d = '0;
							end else begin
								pulse_index_d = pulse_next[PCOUNT_W-1:0];
							end
						end else if (!bi) begin
							bit_index_d = 1'b1;
						end else begin
							bit_index_d = 1'b0;
							part_d      = (p == PART_BOARD) ? PART_INDEX : PART_PREAMBLE;
						end
					end
				end else begin
					tick_count_d = tc_inc[COUNT_WIDTH-1:0];
				end
			end
		end
	end

	// position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q        <= PART_PREAMBLE;
			pulse_index_q <= '0;
			bit_index_q   <= 1'b0;
			half_q        <= 1'b0;
			tick_count_q  <= '0;
			emitters_q    <= '0;
		end else if (step) begin
			part_q        <= part_d;
			pulse_index_q <= pulse_index_d;
			bit_index_q   <= bit_index_d;
			half_q        <= half_d;
			tick_count_q  <= tick_count_d;
			emitters_q    <= emitters_d;
		end
	end

endmodule

FILE: src/ir_pulse_width_beacon_framer.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_beacon_framer
// Four-emitter IR beacon frame generator: preamble, board id, emitter index.
// ----------------------------------------------------------------------------
// Each request is one time tick (advance = 1) or a hold (advance = 0) and
// produces exactly one result: the four emitter envelopes, a frame start flag
// and the current frame part. One request is taken every clock cycle while
// in_stall is low; a request goes through an input register and the frame
// sequencer into the output register, which drives the outputs. The input
// register lets one more request be taken while a result waits in the output
// register on a stalled output. Register writes go through cfg_write/cfg_index/
// cfg_data and apply to the next tick; write them only while no request is in
// flight.
module ir_pulse_width_beacon_framer import irpwb_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [REG_INDEX_W-1:0]   cfg_index,
	input  logic [TICK_REG_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     advance,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [EMITTER_COUNT-1:0] emitter_on,
	output logic                     frame_start,
	output logic [PART_CODE_W-1:0]   frame_part
);

	cfg_t cfg;
	res_t res;
	logic valid_s1;
	logic advance_s1;
	logic valid_s2;
	res_t res_s2;
	logic move_s1;
	logic accept_in;

	irpwb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	irpwb_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (move_s1),
		.advance (advance_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// handshake between the stages
	assign move_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !move_s1;
	assign accept_in = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			advance_s1 <= advance;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign emitter_on  = res_s2.emitter_on;
	assign frame_start = res_s2.frame_start;
	assign frame_part  = res_s2.frame_part;

endmodule

FILE: tb/sv/ir_pulse_width_beacon_framer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_width_beacon_framer_checker
// Watches the register port and both request channels of the beacon framer,
// keeps its own copy of the frame position and registers, predicts the
// envelope of every accepted tick and compares it with the delivered result.
// ----------------------------------------------------------------------------
module ir_pulse_width_beacon_framer_checker import irpwb_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [REG_INDEX_W-1:0]   cfg_index,
	input  logic [TICK_REG_W-1:0]    cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     advance,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [EMITTER_COUNT-1:0] emitter_on,
	input  logic                     frame_start,
	input  logic [PART_CODE_W-1:0]   frame_part,
	output int                       fail_count,
	output int                       pending
);

	// shadow registers and frame position
	cfg_t                     regs;
	logic [PART_CODE_W-1:0]   part;
	logic [PCOUNT_W-1:0]      pulse_idx;
	logic                     bit_idx;
	logic                     half;
	logic [TICK_REG_W-1:0]    tick;
	logic [EMITTER_COUNT-1:0] emitters;

	res_t envelope_q[$];

	// a zero length counts as one tick; 20-bit registers never exceed the counter
	function automatic logic [TICK_REG_W:0] span(input logic [TICK_REG_W-1:0] r);
		return (r == '0) ? 21'd1 : {1'b0, r};
	endfunction

	// envelope of an emitter sending b at the current symbol position
	function automatic logic symbol_on(input logic b);
		logic [TICK_REG_W:0] s;
		logic [TICK_REG_W:0] l;
		s = span(regs.short_ticks);
		l = span(regs.long_ticks);
		if (!half)
			return 1'b1;
		if (!b || l <= s)
			return 1'b0;
		return {1'b0, tick} < (l - s);
	endfunction

	// one tick or hold of the frame sequencer
	task automatic next_envelope(input logic adv, output res_t r);
		logic                     at_start;
		logic [EMITTER_COUNT-1:0] val;
		logic [TICK_REG_W:0]      len;
		logic [PCOUNT_W:0]        next_pulse;
		logic [1:0]               k2;
		logic                     b;
		if (!adv) begin
			r.emitter_on  = emitters;
			r.frame_start = 1'b0;
			r.frame_part  = part;
		end else begin
			at_start = part == CODE_PREAMBLE && pulse_idx == '0 && !bit_idx && !half &&
				tick == '0;
			if (at_start && !regs.run_enable) begin
				// idle at frame start
				emitters = '0;
				r = '0;
			end else begin
				// empty or shortened preamble skips to the board id
				if (part == CODE_PREAMBLE && pulse_idx >= regs.preamble_count) begin
					part      = CODE_BOARD;
					pulse_idx = '0;
					bit_idx   = 1'b0;
					half      = 1'b0;
					tick      = '0;
				end
				val = '0;
				if (part == CODE_PREAMBLE) begin
					val = half ? '0 : '1;
				end else if (part == CODE_BOARD) begin
					b = bit_idx ? regs.board_id[0] : regs.board_id[1];
					val = symbol_on(b) ? '1 : '0;
				end else begin
					for (int k = 0; k < EMITTER_COUNT; k++) begin
						k2 = k[1:0];
						b = bit_idx ? k2[0] : k2[1];
						val[k] = symbol_on(b);
					end
				end
				emitters      = val;
				r.emitter_on  = val;
				r.frame_start = at_start;
				r.frame_part  = part;

				// advance the position within the frame
				if (part == CODE_PREAMBLE)
					len = span(regs.preamble_ticks);
				else
					len = half ? span(regs.long_ticks) : span(regs.short_ticks);
				if ({1'b0, tick} + 21'd1 >= len) begin
					tick = '0;
					if (!half) begin
						half = 1'b1;
					end else begin
						half = 1'b0;
						if (part == CODE_PREAMBLE) begin
							next_pulse = {1'b0, pulse_idx} + 5'd1;
							if (next_pulse >= {1'b0, regs.preamble_count}) begin
								part      = CODE_BOARD;
								pulse_idx = '0;
							end else begin
								pulse_idx = next_pulse[PCOUNT_W-1:0];
							end
						end else if (!bit_idx) begin
							bit_idx = 1'b1;
						end else begin
							bit_idx = 1'b0;
							part = (part == CODE_BOARD) ? CODE_INDEX : CODE_PREAMBLE;
						end
					end
				end else begin
					tick = tick + 1'b1;
				end
			end
		end
	endtask

	// register writes, prediction on accepted requests, comparison on results
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			regs.preamble_count = RST_PREAMBLE_COUNT;
			regs.board_id       = RST_BOARD_ID;
			regs.preamble_ticks = RST_PREAMBLE_TICKS;
			regs.short_ticks    = RST_SHORT_TICKS;
			regs.long_ticks     = RST_LONG_TICKS;
			regs.run_enable     = 1'b0;
			part       = CODE_PREAMBLE;
			pulse_idx  = '0;
			bit_idx    = 1'b0;
			half       = 1'b0;
			tick       = '0;
			emitters   = '0;
			envelope_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_PREAMBLE_COUNT: regs.preamble_count = cfg_data[PCOUNT_W-1:0];
					REG_BOARD_ID:       regs.board_id       = cfg_data[BOARD_W-1:0];
					REG_PREAMBLE_TICKS: regs.preamble_ticks = cfg_data;
					REG_SHORT_TICKS:    regs.short_ticks    = cfg_data;
					REG_LONG_TICKS:     regs.long_ticks     = cfg_data;
					REG_RUN_ENABLE:     regs.run_enable     = cfg_data[0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				next_envelope(advance, want);
				envelope_q.push_back(want);
			end

			if (out_valid && !out_stall) begin
				got = {emitter_on, frame_start, frame_part};
				if (envelope_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: emitters %h start %b part %0d",
							emitter_on, frame_start, frame_part);
				end else begin
					want = envelope_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %h/%b/%0d got %h/%b/%0d",
								want.emitter_on, want.frame_start, want.frame_part,
								emitter_on, frame_start, frame_part);
					end
				end
			end
			pending = envelope_q.size();
		end
	end

endmodule

FILE: tb/sv/ir_pulse_width_beacon_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_width_beacon_framer_tb
// Drives tick and hold requests into the beacon framer in bursts under a
// random output stall pattern, reprograms the timing registers between
// phases, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module ir_pulse_width_beacon_framer_tb;
	import irpwb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_TICKS  = 630;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_write;
	logic [REG_INDEX_W-1:0]   cfg_index;
	logic [TICK_REG_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic                     advance;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [EMITTER_COUNT-1:0] emitter_on;
	logic                     frame_start;
	logic [PART_CODE_W-1:0]   frame_part;
	int                       fail_count;
	int                       pending;
	int                       cycle_count = 0;
	int                       stall_mode = 0;
	int                       stall_left = 0;

	ir_pulse_width_beacon_framer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.emitter_on  (emitter_on),
		.frame_start (frame_start),
		.frame_part  (frame_part)
	);

	ir_pulse_width_beacon_framer_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.emitter_on  (emitter_on),
		.frame_start (frame_start),
		.frame_part  (frame_part),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// output stall pattern: segments of free flow, light, heavy and near-blocked
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 80);
		end
		stall_left--;
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 3) == 0);
			2:       out_stall <= ($urandom_range(0, 1) == 1);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// one register write, called at a falling edge
	task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
		input logic [TICK_REG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// one request held until accepted, returns at the next falling edge
	task automatic send_tick(input logic adv);
		in_valid <= 1'b1;
		advance  <= adv;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// drop the request, wait for every result, then stay idle before returning
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// random settings; narrow registers get junk in the unused data bits
	task automatic pick_settings(input bit extreme);
		logic [TICK_REG_W-1:0] junk;
		junk = TICK_REG_W'($urandom);
		if (extreme) begin
			write_reg(REG_PREAMBLE_COUNT, (junk & 20'hFFFF0) |
				($urandom_range(0, 1) ? 20'd15 : 20'd0));
			write_reg(REG_PREAMBLE_TICKS, 20'hFFFFF);
			write_reg(REG_SHORT_TICKS, $urandom_range(0, 1) ? 20'hFFFFF : 20'h00001);
			write_reg(REG_LONG_TICKS, 20'hFFFFF);
			write_reg(REG_RUN_ENABLE, (junk & 20'hFFFFE) | 1'b1);
		end else begin
			if ($urandom_range(0, 1))
				write_reg(REG_PREAMBLE_COUNT, (junk & 20'hFFFF0) | TICK_REG_W'(
					$urandom_range(0, 4) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 3)));
			if ($urandom_range(0, 1))
				write_reg(REG_BOARD_ID, (junk & 20'hFFFFC) | TICK_REG_W'($urandom_range(0, 3)));
			if ($urandom_range(0, 1))
				write_reg(REG_PREAMBLE_TICKS, TICK_REG_W'($urandom_range(0, 4)));
			if ($urandom_range(0, 1))
				write_reg(REG_SHORT_TICKS, TICK_REG_W'($urandom_range(0, 4)));
			if ($urandom_range(0, 1))
				write_reg(REG_LONG_TICKS, TICK_REG_W'($urandom_range(0, 6)));
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_RUN_ENABLE, (junk & 20'hFFFFE) | ($urandom_range(0, 5) != 0));
		end
		cfg_write <= 1'b0;
	endtask

	initial begin
		int  sent;
		int  phase;
		int  n;
		int  burst_left;
		int  gap;
		bit  extreme;
		logic [TICK_REG_W-1:0] wide;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		advance   = 1'b0;
		arst_n    = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle with reset settings: frame start held, emitters off
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		settle();

		// empty preamble, zero lengths, long not above short
		write_reg(REG_PREAMBLE_COUNT, 20'hFFFF0);
		write_reg(REG_BOARD_ID, 20'hFFFF3);
		write_reg(REG_PREAMBLE_TICKS, 20'd0);
		write_reg(REG_SHORT_TICKS, 20'd0);
		write_reg(REG_LONG_TICKS, 20'd0);
		write_reg(REG_RUN_ENABLE, 20'd1);
		cfg_write <= 1'b0;
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b1);
		settle();

		// full-length preamble, ticks with holds in the middle
		write_reg(REG_PREAMBLE_COUNT, 20'd15);
		write_reg(REG_BOARD_ID, 20'd2);
		write_reg(REG_PREAMBLE_TICKS, 20'd1);
		write_reg(REG_SHORT_TICKS, 20'd2);
		write_reg(REG_LONG_TICKS, 20'd5);
		cfg_write <= 1'b0;
		for (int i = 0; i < 12; i++)
			send_tick(i % 4 != 3);
		settle();

		// random phases with bursty requests
		sent  = 0;
		phase = 0;
		burst_left = 0;
		while (sent < RANDOM_TICKS) begin
			extreme = (phase % 5 == 4);
			pick_settings(extreme);
			n = extreme ? 20 : $urandom_range(30, 70);
			for (int i = 0; i < n; i++) begin
				if (burst_left == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					if (gap > 0) begin
						in_valid <= 1'b0;
						repeat (gap) @(negedge clk);
					end
					burst_left = $urandom_range(1, 24);
				end
				send_tick($urandom_range(0, 4) != 0);
				burst_left--;
				sent++;
			end
			settle();
			phase++;
		end

		// new board id with junk in the unused data bits, then five more ticks
		wide = TICK_REG_W'($urandom);
		write_reg(REG_BOARD_ID, (wide & 20'hFFFFC) | 2'd1);
		cfg_write <= 1'b0;
		for (int i = 0; i < 5; i++)
			send_tick(1'b1);
		settle();

		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: files.f
src/irpwb_pkg.sv
src/irpwb_cfg.sv
src/irpwb_seq.sv
src/ir_pulse_width_beacon_framer.sv
tb/sv/ir_pulse_width_beacon_framer_checker.sv
tb/sv/ir_pulse_width_beacon_framer_tb.sv
